@@ rtl/adgc_pkg.sv @@
// Package for the audio ducking gain controller: beat types, register indexes, gain constants.
package adgc_pkg;

  // Q16 unity gain and the field widths
  localparam logic [16:0] UnityGain = 17'd65536;
  localparam int unsigned LevelW = 16;
  localparam int unsigned GainW = 17;
  localparam int unsigned TickW = 16;

  // gain below 0.99 of unity: gain * 100 < 99 * 65536
  localparam logic [16:0] DuckedLimit = 17'd64881;
  // gain below 0.95 of unity: gain * 20 < 19 * 65536
  localparam logic [16:0] HoldDuckLimit = 17'd62260;

  // divide by ten: x * ceil(2^23 / 10) >> 23, exact for x below 2^22
  localparam logic [19:0] DivTenRecip = 20'd838861;
  localparam int unsigned DivTenShift = 23;

  // configuration register indexes
  localparam logic [2:0] CfgThreshold = 3'd0;
  localparam logic [2:0] CfgActDelay = 3'd1;
  localparam logic [2:0] CfgRecDelay = 3'd2;
  localparam logic [2:0] CfgAttackStep = 3'd3;
  localparam logic [2:0] CfgReleaseStep = 3'd4;
  localparam logic [2:0] CfgDuckGain = 3'd5;

  // input beat: one control tick
  typedef struct packed {
    logic              source_present;
    logic [LevelW-1:0] source_peak;
    logic              enable;
  } adgc_in_t;

  // result beat
  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic              is_ducked;
    logic              is_playing;
    logic [2:0]        phase_now;
    logic [LevelW-1:0] smoothed_level;
  } adgc_out_t;

endpackage

@@ rtl/audio_ducking_gain_controller.sv @@
// Sidechain audio ducker: level smoothing, phase machine with delays, gain ramp.
// The input beat is registered in the input register, then the result beat in the result register.
// Throughput: one tick per cycle unless the result stalls; the path from the input register
// through the divide-by-ten multiply, the phase machine and the gain ramp sets the clock.
// Reset: phase idle, tick count zero, level zero, gain and target unity,
// configuration registers to their documented defaults.
module audio_ducking_gain_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  adgc_pkg::adgc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output adgc_pkg::adgc_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_addr_i,
  input  logic [16:0]         cfg_data_i
);
  import adgc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_WAIT_DUCK    = 3'd1,
    PH_ATTACK       = 3'd2,
    PH_WAIT_RESTORE = 3'd3,
    PH_RELEASE      = 3'd4
  } phase_e;

  // configuration registers
  logic [LevelW-1:0] threshold_q;
  logic [TickW-1:0]  act_delay_q, rec_delay_q;
  logic [GainW-1:0]  attack_step_q, release_step_q, duck_gain_q;

  // tick state
  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  ticks_q, ticks_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [GainW-1:0]  gain_q, gain_d;
  logic [GainW-1:0]  target_q, target_d;

  // pipeline registers
  adgc_in_t  in_q;
  logic      in_valid_q;
  adgc_out_t out_q, out_d;
  logic      out_valid_q;
  logic      advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= 16'd655;
      act_delay_q    <= '0;
      rec_delay_q    <= '0;
      attack_step_q  <= UnityGain;
      release_step_q <= UnityGain;
      duck_gain_q    <= 17'd32768;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CfgThreshold:   threshold_q    <= cfg_data_i[LevelW-1:0];
        CfgActDelay:    act_delay_q    <= cfg_data_i[TickW-1:0];
        CfgRecDelay:    rec_delay_q    <= cfg_data_i[TickW-1:0];
        CfgAttackStep:  attack_step_q  <= cfg_data_i;
        CfgReleaseStep: release_step_q <= cfg_data_i;
        CfgDuckGain:    duck_gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-tick datapath
  phase_e            ph0;
  logic [TickW-1:0]  tk0, tk_inc;
  logic [GainW-1:0]  tgt0, step, diff, duck;
  logic [19:0]       mix;
  logic [39:0]       prod;
  logic              playing;
  phase_e            duck_entry, restore_entry;

  always_comb begin
    // force idle and unity target while disabled
    ph0  = phase_q;
    tk0  = ticks_q;
    tgt0 = target_q;
    if (!in_q.enable) begin
      ph0  = PH_IDLE;
      tk0  = '0;
      tgt0 = UnityGain;
    end

    // smooth the level: fast rise rounded up, slow fall rounded down
    if (in_q.source_peak > level_q) begin
      mix = {4'd0, level_q} * 20'd3 + {4'd0, in_q.source_peak} * 20'd7 + 20'd9;
    end else begin
      mix = {4'd0, level_q} * 20'd6 + {4'd0, in_q.source_peak} * 20'd4;
    end
    prod    = {20'd0, mix} * {20'd0, DivTenRecip};
    level_d = in_q.source_present ? prod[DivTenShift+LevelW-1:DivTenShift] : level_q;
    playing = in_q.source_present && (level_d > threshold_q);

    // ramp toward the previous target without overshoot
    step = (tgt0 < gain_q) ? attack_step_q : release_step_q;
    if (step == '0) begin
      step = 17'd1;
    end
    gain_d = gain_q;
    diff   = '0;
    if (gain_q < tgt0) begin
      diff   = tgt0 - gain_q;
      gain_d = (diff <= step) ? tgt0 : gain_q + step;
    end else if (gain_q > tgt0) begin
      diff   = gain_q - tgt0;
      gain_d = (diff <= step) ? tgt0 : gain_q - step;
    end

    // phase machine and next target
    duck_entry    = (act_delay_q != '0) ? PH_WAIT_DUCK : PH_ATTACK;
    restore_entry = (rec_delay_q != '0) ? PH_WAIT_RESTORE : PH_RELEASE;
    tk_inc        = (tk0 != '1) ? tk0 + 16'd1 : tk0;
    duck          = (duck_gain_q > UnityGain) ? UnityGain : duck_gain_q;
    phase_d       = ph0;
    ticks_d       = tk0;
    target_d      = tgt0;
    if (in_q.enable) begin
      ticks_d = tk_inc;
      case (ph0)
        PH_IDLE: begin
          if (playing) begin
            phase_d = duck_entry;
            ticks_d = '0;
          end
        end
        PH_WAIT_DUCK: begin
          if (playing && tk_inc >= act_delay_q) begin
            phase_d = PH_ATTACK;
            ticks_d = '0;
          end else if (!playing) begin
            phase_d = PH_IDLE;
            ticks_d = '0;
          end
        end
        PH_ATTACK: begin
          if (!playing) begin
            phase_d = restore_entry;
            ticks_d = '0;
          end
        end
        PH_WAIT_RESTORE: begin
          if (!playing && tk_inc >= rec_delay_q) begin
            phase_d = PH_RELEASE;
            ticks_d = '0;
          end else if (playing) begin
            phase_d = duck_entry;
            ticks_d = '0;
          end
        end
        PH_RELEASE: begin
          if (playing) begin
            phase_d = duck_entry;
            ticks_d = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      if (phase_d == PH_ATTACK || phase_d == PH_WAIT_RESTORE) begin
        target_d = duck;
      end else if (phase_d == PH_WAIT_DUCK && gain_d < HoldDuckLimit) begin
        target_d = duck;
      end else begin
        target_d = UnityGain;
      end
    end

    // assemble the result beat
    out_d.gain           = gain_d;
    out_d.is_ducked      = gain_d < DuckedLimit;
    out_d.is_playing     = playing;
    out_d.phase_now      = phase_d;
    out_d.smoothed_level = level_d;
  end

  // hold state and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      level_q     <= '0;
      gain_q      <= UnityGain;
      target_q    <= UnityGain;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q     <= phase_d;
        ticks_q     <= ticks_d;
        level_q     <= level_d;
        gain_q      <= gain_d;
        target_q    <= target_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture beats
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // gain never leaves the unity range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= UnityGain && target_q <= UnityGain)
    else $error("gain or target above unity");

  // a disabled tick leaves the phase idle with a unity target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.enable |=> phase_q == PH_IDLE && target_q == UnityGain)
    else $error("disabled tick did not force idle");

  // the result beat reports the state just committed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_q.gain == gain_q && out_q.phase_now == phase_q)
    else $error("result beat out of step with state");

  // the ducked flag follows the reported gain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.is_ducked == (out_data_o.gain < DuckedLimit))
    else $error("ducked flag disagrees with gain");

endmodule
